/* design/cetl_pkg.sv */
// Shared types and constants for the color escape text layout block.
// No dependencies; imported by every module of the block.
package cetl_pkg;

    // Fixed geometry of the glyph atlas
    localparam int CHAR_WIDTH    = 8;
    localparam int ATLAS_COLUMNS = 256 / CHAR_WIDTH;
    localparam int ATLAS_BITS    = $clog2(ATLAS_COLUMNS);
    localparam int CHAR_SHIFT    = $clog2(CHAR_WIDTH);

    // Field widths
    localparam int CP_W     = 21;
    localparam int COORD_W  = 16;
    localparam int GH_W     = 6;
    localparam int ESC_W    = 8;
    localparam int COLOR_W  = 8;
    localparam int SRC_X_W  = 8;
    localparam int RGB_W    = 24;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int SLOTS    = 3;
    localparam int SLOT_W   = $clog2(SLOTS);

    // Special codepoints
    localparam logic [CP_W-1:0] INVALID_CP = CP_W'(24'h00FFFD);
    localparam logic [CP_W-1:0] NEWLINE_CP = CP_W'(8'h0A);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_ENABLE = 2'd2;

    // Input opcodes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_CHAR   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // Configuration settings as seen by front and back
    typedef struct packed {
        logic [GH_W-1:0]  line_height;
        logic [ESC_W-1:0] escape_code;
        logic             escape_enable;
    } cfg_t;

    // Action carried from the front to the back
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_GLYPH   = 2'd1,
        ACT_NEWLINE = 2'd2,
        ACT_START   = 2'd3
    } act_t;

    typedef struct packed {
        act_t            kind;
        logic [CP_W-1:0] cp;
        logic            last;
    } slot_t;

    // One queue entry: all actions caused by one input item
    typedef struct packed {
        slot_t [SLOTS-1:0]  slot;
        logic [SLOT_W-1:0]  last_idx;
        logic [COLOR_W-1:0] colors;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
    } entry_t;

endpackage

/* design/cetl_front.sv */
// Front end: accepts input items, parses color escapes, builds action lists.
// Depends on cetl_pkg.
module cetl_front
    import cetl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                opcode,
    input  logic [CP_W-1:0]           codepoint,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic [COLOR_W-1:0]        start_colors,
    input  logic                      q_full,
    output logic                      push,
    output entry_t                    entry
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_ESC   = 3'b010,
        PH_DIGIT = 3'b100
    } phase_t;

    typedef struct packed {
        slot_t slot;
        logic  esc_hit;
    } proc_t;

    phase_t             phase_reg, phase_next;
    logic [ESC_W-1:0]   held_reg, held_next;
    logic [COLOR_W-1:0] colors_reg, colors_next;

    logic               accept;
    logic               c_hex;
    proc_t              c_proc;
    proc_t              esc_proc;
    slot_t              held_slot;
    slot_t [SLOTS-1:0]  raw;
    slot_t [SLOTS-1:0]  list;
    logic [SLOT_W:0]    n;
    logic               later_glyph;

    function automatic logic is_hex(input logic [CP_W-1:0] c);
        return (c >= CP_W'("0") && c <= CP_W'("9")) ||
               (c >= CP_W'("a") && c <= CP_W'("f")) ||
               (c >= CP_W'("A") && c <= CP_W'("F"));
    endfunction

    function automatic logic [3:0] hex_val(input logic [CP_W-1:0] c);
        logic [CP_W-1:0] v;
        v = '0;
        if (c >= CP_W'("0") && c <= CP_W'("9")) v = c - CP_W'("0");
        else if (c >= CP_W'("a") && c <= CP_W'("f")) v = c - CP_W'("a") + CP_W'(10);
        else if (c >= CP_W'("A") && c <= CP_W'("F")) v = c - CP_W'("A") + CP_W'(10);
        return v[3:0];
    endfunction

    // Classify one codepoint with no escape pending
    function automatic proc_t classify(input logic [CP_W-1:0] c, input logic allow,
                                       input cfg_t k);
        proc_t p;
        p.slot.cp   = c;
        p.slot.last = 1'b0;
        p.slot.kind = ACT_NONE;
        p.esc_hit   = 1'b0;
        if (c == INVALID_CP) p.slot.kind = ACT_NONE;
        else if (allow && k.escape_enable && c == CP_W'(k.escape_code)) p.esc_hit = 1'b1;
        else if (c == NEWLINE_CP) p.slot.kind = ACT_NEWLINE;
        else p.slot.kind = ACT_GLYPH;
        return p;
    endfunction

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Parse step and raw action list
    always_comb
    begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        colors_next = colors_reg;
        c_hex       = is_hex(codepoint);
        c_proc      = classify(codepoint, 1'b1, cfg);
        esc_proc    = classify(CP_W'(cfg.escape_code), 1'b0, cfg);
        if (cfg.escape_enable && held_reg == cfg.escape_code)
        begin
            held_slot = esc_proc.slot;
        end
        else
        begin
            held_slot = '{kind: ACT_GLYPH, cp: CP_W'(held_reg), last: 1'b0};
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            raw[i] = '{kind: ACT_NONE, cp: '0, last: 1'b0};
        end
        case (opcode)
            OP_START:
            begin
                raw[0].kind = ACT_START;
                colors_next = start_colors;
                phase_next  = PH_IDLE;
                held_next   = '0;
            end
            OP_CHAR:
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        raw[0] = c_proc.slot;
                        if (c_proc.esc_hit) phase_next = PH_ESC;
                    end
                    PH_ESC:
                    begin
                        if (c_hex)
                        begin
                            held_next  = codepoint[ESC_W-1:0];
                            phase_next = PH_DIGIT;
                        end
                        else
                        begin
                            raw[0]     = esc_proc.slot;
                            raw[1]     = c_proc.slot;
                            phase_next = c_proc.esc_hit ? PH_ESC : PH_IDLE;
                        end
                    end
                    PH_DIGIT:
                    begin
                        if (c_hex)
                        begin
                            colors_next = {hex_val(CP_W'(held_reg)), hex_val(codepoint)};
                            phase_next  = PH_IDLE;
                        end
                        else
                        begin
                            raw[0]     = esc_proc.slot;
                            raw[1]     = held_slot;
                            raw[2]     = c_proc.slot;
                            phase_next = c_proc.esc_hit ? PH_ESC : PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            OP_FINISH:
            begin
                if (phase_reg == PH_ESC)
                begin
                    raw[0] = esc_proc.slot;
                end
                else if (phase_reg == PH_DIGIT)
                begin
                    raw[0] = esc_proc.slot;
                    raw[1] = held_slot;
                end
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Compact the list and mark the last glyph
    always_comb
    begin
        n = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            list[i] = '{kind: ACT_NONE, cp: '0, last: 1'b0};
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (raw[i].kind != ACT_NONE)
            begin
                list[n[SLOT_W-1:0]] = raw[i];
                n = n + 1'b1;
            end
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            later_glyph = 1'b0;
            for (int j = i + 1; j < SLOTS; j++)
            begin
                if (list[j].kind == ACT_GLYPH) later_glyph = 1'b1;
            end
            list[i].last = (list[i].kind == ACT_GLYPH) && !later_glyph;
        end
        entry.slot     = list;
        entry.last_idx = SLOT_W'(n - 1'b1);
        entry.colors   = colors_reg;
        entry.origin_x = origin_x;
        entry.origin_y = origin_y;
    end

    assign push = accept && (n != '0);

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            held_reg   <= '0;
            colors_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            held_reg   <= held_next;
            colors_reg <= colors_next;
        end
    end

endmodule

/* design/cetl_queue.sv */
// Short queue of action lists between front and back ends.
// Depends on cetl_pkg.
module cetl_queue
    import cetl_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    input  logic   pop,
    output entry_t head,
    output logic   empty,
    output logic   full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)  rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        else if (do_pop && !do_push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push) mem[wr_ptr_reg] <= push_data;
    end

endmodule

/* design/cetl_back.sv */
// Back end: walks queued actions, keeps the cursor, drives draw commands.
// Depends on cetl_pkg.
module cetl_back
    import cetl_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  entry_t                     head,
    input  logic                       q_empty,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [COORD_W-1:0]  dest_x,
    output logic signed [COORD_W-1:0]  dest_y,
    output logic [SRC_X_W-1:0]         src_x,
    output logic [CP_W-1:0]            src_y,
    output logic                       bg_draw,
    output logic [RGB_W-1:0]           bg_rgb,
    output logic [RGB_W-1:0]           fg_rgb,
    output logic                       last_result
);

    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [COORD_W-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_W-1:0] cursor_y_reg, cursor_y_next;
    logic [COORD_W-1:0] line_x_reg, line_x_next;
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] dest_x_reg, dest_y_reg;
    logic [SRC_X_W-1:0] src_x_reg;
    logic [CP_W-1:0]    src_y_reg;
    logic               bg_draw_reg;
    logic [RGB_W-1:0]   bg_rgb_reg, fg_rgb_reg;
    logic               last_reg;

    slot_t              cur;
    logic               out_free;
    logic               go;
    logic               emit;
    logic [CP_W:0]      prod;
    logic [RGB_W-1:0]   bg_col, fg_col;

    function automatic logic [RGB_W-1:0] palette(input logic [3:0] c);
        logic [RGB_W-1:0] rgb;
        case (c)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'h0000aa;
            4'd2:    rgb = 24'h00aa00;
            4'd3:    rgb = 24'h00aaaa;
            4'd4:    rgb = 24'haa0000;
            4'd5:    rgb = 24'haa00aa;
            4'd6:    rgb = 24'haa5500;
            4'd7:    rgb = 24'haaaaaa;
            4'd8:    rgb = 24'h555555;
            4'd9:    rgb = 24'h5555ff;
            4'd10:   rgb = 24'h55ff55;
            4'd11:   rgb = 24'h55ffff;
            4'd12:   rgb = 24'hff5555;
            4'd13:   rgb = 24'hff55ff;
            4'd14:   rgb = 24'hffff55;
            default: rgb = 24'hffffff;
        endcase
        return rgb;
    endfunction

    assign cur      = head.slot[idx_reg];
    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = (cur.kind == ACT_GLYPH);
    assign go       = !q_empty && (!emit || out_free);
    assign pop      = go && (idx_reg == head.last_idx);
    assign prod     = (CP_W + 1)'(cur.cp[CP_W-1:ATLAS_BITS]) * (CP_W + 1)'(cfg.line_height);
    assign bg_col   = palette(head.colors[7:4]);
    assign fg_col   = palette(head.colors[3:0]);

    // Action step: cursor and slot index
    always_comb
    begin
        idx_next      = idx_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        line_x_next   = line_x_reg;
        if (go)
        begin
            idx_next = pop ? '0 : idx_reg + 1'b1;
            case (cur.kind)
                ACT_GLYPH:
                begin
                    cursor_x_next = cursor_x_reg + COORD_W'(CHAR_WIDTH);
                end
                ACT_NEWLINE:
                begin
                    cursor_y_next = cursor_y_reg + COORD_W'(cfg.line_height);
                    cursor_x_next = line_x_reg;
                end
                ACT_START:
                begin
                    cursor_x_next = head.origin_x;
                    cursor_y_next = head.origin_y;
                    line_x_next   = head.origin_x;
                end
                default:
                begin
                    cursor_x_next = cursor_x_reg;
                end
            endcase
        end
    end

    // Output register handshake
    always_comb
    begin
        if (go && emit) out_valid_next = 1'b1;
        else if (out_stall) out_valid_next = out_valid_reg;
        else out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            line_x_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            line_x_reg    <= line_x_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Draw command payload
    always_ff @(posedge clk)
    begin
        if (go && emit)
        begin
            dest_x_reg  <= cursor_x_reg;
            dest_y_reg  <= cursor_y_reg;
            src_x_reg   <= SRC_X_W'(cur.cp[ATLAS_BITS-1:0]) << CHAR_SHIFT;
            src_y_reg   <= prod[CP_W-1:0];
            bg_draw_reg <= (bg_col != '0);
            bg_rgb_reg  <= bg_col;
            fg_rgb_reg  <= fg_col;
            last_reg    <= cur.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign dest_x      = dest_x_reg;
    assign dest_y      = dest_y_reg;
    assign src_x       = src_x_reg;
    assign src_y       = src_y_reg;
    assign bg_draw     = bg_draw_reg;
    assign bg_rgb      = bg_rgb_reg;
    assign fg_rgb      = fg_rgb_reg;
    assign last_result = last_reg;

endmodule

/* design/color_escape_text_layout_top.sv */
// Top level of the color escape text layout block: configuration registers
// and the front end, action queue and back end. Depends on cetl_pkg.
//
// Takes one item per cycle while the action queue is not full. Each item
// becomes a list of up to three actions (glyph draw, newline, string start)
// in the front end; the back end carries out one action per cycle, unless
// an output stall holds back a draw, into a single output register. An item
// gives one action for a printable character, newline or start, one
// to three for a broken color escape, none when it yields no action
// (escape or digit held, invalid codepoint, finish with nothing pending,
// unused opcode). A draw passes through the action queue and then the
// output register. The action queue (QUEUE_DEPTH entries) absorbs bursts
// and output stalls; input stall rises only when it is full. Configuration
// must be written only while the block is idle; the block never checks it.
module color_escape_text_layout_top
    import cetl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_addr,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 opcode,
    input  logic [CP_W-1:0]            codepoint,
    input  logic signed [COORD_W-1:0]  origin_x,
    input  logic signed [COORD_W-1:0]  origin_y,
    input  logic [COLOR_W-1:0]         start_colors,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [COORD_W-1:0]  dest_x,
    output logic signed [COORD_W-1:0]  dest_y,
    output logic [SRC_X_W-1:0]         src_x,
    output logic [CP_W-1:0]            src_y,
    output logic                       bg_draw,
    output logic [RGB_W-1:0]           bg_rgb,
    output logic [RGB_W-1:0]           fg_rgb,
    output logic                       last_result
);

    cfg_t   cfg_reg;
    logic   q_full;
    logic   q_empty;
    logic   push;
    logic   pop;
    entry_t push_data;
    entry_t head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_height   <= GH_W'(8);
            cfg_reg.escape_code   <= ESC_W'(27);
            cfg_reg.escape_enable <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_LINE_HEIGHT:   cfg_reg.line_height   <= cfg_data[GH_W-1:0];
                CFG_ESCAPE_CODE:   cfg_reg.escape_code   <= cfg_data[ESC_W-1:0];
                CFG_ESCAPE_ENABLE: cfg_reg.escape_enable <= cfg_data[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Escape parsing front end
    cetl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .codepoint    (codepoint),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .start_colors (start_colors),
        .q_full       (q_full),
        .push         (push),
        .entry        (push_data)
    );

    // Action queue
    cetl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Layout back end
    cetl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .dest_x      (dest_x),
        .dest_y      (dest_y),
        .src_x       (src_x),
        .src_y       (src_y),
        .bg_draw     (bg_draw),
        .bg_rgb      (bg_rgb),
        .fg_rgb      (fg_rgb),
        .last_result (last_result)
    );

endmodule

/* test/color_escape_text_layout_top_tb.sv */
// Self-checking testbench for color_escape_text_layout_top: a directed script
// and random text streams, checked draw by draw against a built-in predictor.
// Depends on cetl_pkg and the block's RTL only.
module color_escape_text_layout_top_tb;
    import cetl_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         DRAIN_CYCLES = 24;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         PHASE_ITEMS  = 50;

    // One draw command as it leaves the block
    typedef struct packed {
        logic signed [COORD_W-1:0] dest_x;
        logic signed [COORD_W-1:0] dest_y;
        logic [SRC_X_W-1:0]        src_x;
        logic [CP_W-1:0]           src_y;
        logic                      bg_draw;
        logic [RGB_W-1:0]          bg_rgb;
        logic [RGB_W-1:0]          fg_rgb;
        logic                      last_result;
    } draw_t;

    typedef enum logic [1:0] {ESC_IDLE, ESC_SEEN, ESC_DIGIT} esc_state_t;
    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    // One line of the directed script
    typedef struct {
        row_kind_t            kind;
        logic [1:0]           op;
        logic [CP_W-1:0]      cp;
        logic [COORD_W-1:0]   ox;
        logic [COORD_W-1:0]   oy;
        logic [COLOR_W-1:0]   col;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        bit                   typed;
        draw_t                want;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_addr;
    logic [CFG_W-1:0]           cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 opcode;
    logic [CP_W-1:0]            codepoint;
    logic signed [COORD_W-1:0]  origin_x;
    logic signed [COORD_W-1:0]  origin_y;
    logic [COLOR_W-1:0]         start_colors;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [COORD_W-1:0]  dest_x;
    logic signed [COORD_W-1:0]  dest_y;
    logic [SRC_X_W-1:0]         src_x;
    logic [CP_W-1:0]            src_y;
    logic                       bg_draw;
    logic [RGB_W-1:0]           bg_rgb;
    logic [RGB_W-1:0]           fg_rgb;
    logic                       last_result;

    color_escape_text_layout_top dut (.*);

    // Predicted layout state and register copies
    logic [COORD_W-1:0] pen_x, pen_y, margin_x;
    logic [COLOR_W-1:0] colors;
    esc_state_t         esc_state;
    logic [7:0]         held;
    logic [GH_W-1:0]    line_h;
    logic [ESC_W-1:0]   esc_cp;
    logic               esc_on;

    draw_t     item_draws[$];
    draw_t     expected_draws[$];
    stim_row_t script[$];
    int        mismatches;
    int        burst_left;
    int        items_sent;

    wire in_xfer  = in_valid && !in_stall;
    wire out_xfer = out_valid && !out_stall;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic logic [RGB_W-1:0] cga_rgb(input logic [3:0] idx);
        case (idx)
            4'd0:    return 24'h000000;
            4'd1:    return 24'h0000aa;
            4'd2:    return 24'h00aa00;
            4'd3:    return 24'h00aaaa;
            4'd4:    return 24'haa0000;
            4'd5:    return 24'haa00aa;
            4'd6:    return 24'haa5500;
            4'd7:    return 24'haaaaaa;
            4'd8:    return 24'h555555;
            4'd9:    return 24'h5555ff;
            4'd10:   return 24'h55ff55;
            4'd11:   return 24'h55ffff;
            4'd12:   return 24'hff5555;
            4'd13:   return 24'hff55ff;
            4'd14:   return 24'hffff55;
            default: return 24'hffffff;
        endcase
    endfunction

    // ASCII hex digits only, judged on the whole codepoint
    function automatic bit is_hex(input logic [CP_W-1:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [CP_W-1:0] c);
        if (c >= "0" && c <= "9")
            return 4'(c - "0");
        if (c >= "a" && c <= "f")
            return 4'(c - "a" + 10);
        if (c >= "A" && c <= "F")
            return 4'(c - "A" + 10);
        return 4'd0;
    endfunction

    function automatic void draw_glyph(input logic [CP_W-1:0] c);
        draw_t d;
        if (item_draws.size() >= SLOTS)
            return;
        d.dest_x      = pen_x;
        d.dest_y      = pen_y;
        d.src_x       = SRC_X_W'((c % ATLAS_COLUMNS) * CHAR_WIDTH);
        d.src_y       = CP_W'((c / ATLAS_COLUMNS) * line_h);
        d.bg_rgb      = cga_rgb(colors[7:4]);
        d.bg_draw     = (d.bg_rgb != 24'h0);
        d.fg_rgb      = cga_rgb(colors[3:0]);
        d.last_result = 1'b0;
        item_draws.push_back(d);
        pen_x = pen_x + COORD_W'(CHAR_WIDTH);
    endfunction

    // Codepoint with no escape pending
    function automatic void place_char(input logic [CP_W-1:0] c, input bit allow_esc);
        if (c == INVALID_CP)
            return;
        if (allow_esc && esc_on && c == CP_W'(esc_cp)) begin
            esc_state = ESC_SEEN;
            return;
        end
        if (c == NEWLINE_CP) begin
            pen_y = pen_y + COORD_W'(line_h);
            pen_x = margin_x;
            return;
        end
        draw_glyph(c);
    endfunction

    function automatic void feed_char(input logic [CP_W-1:0] c);
        if (esc_state == ESC_DIGIT) begin
            if (is_hex(c)) begin
                colors    = {hex_nibble(CP_W'(held)), hex_nibble(c)};
                esc_state = ESC_IDLE;
                return;
            end
            // broken after one digit: escape and digit become text
            esc_state = ESC_IDLE;
            place_char(CP_W'(esc_cp), 1'b0);
            place_char(CP_W'(held), 1'b1);
        end
        if (esc_state == ESC_SEEN) begin
            if (is_hex(c)) begin
                held      = c[7:0];
                esc_state = ESC_DIGIT;
                return;
            end
            esc_state = ESC_IDLE;
            place_char(CP_W'(esc_cp), 1'b0);
        end
        place_char(c, 1'b1);
    endfunction

    function automatic void flush_escape();
        if (esc_state == ESC_DIGIT) begin
            esc_state = ESC_IDLE;
            place_char(CP_W'(esc_cp), 1'b0);
            place_char(CP_W'(held), 1'b1);
        end
        if (esc_state == ESC_SEEN) begin
            esc_state = ESC_IDLE;
            place_char(CP_W'(esc_cp), 1'b0);
        end
        esc_state = ESC_IDLE;
    endfunction

    // Works out the draws of one accepted item and queues them
    function automatic void predict_draws(input logic [1:0] op, input logic [CP_W-1:0] cp,
                                          input logic [COORD_W-1:0] ox,
                                          input logic [COORD_W-1:0] oy,
                                          input logic [COLOR_W-1:0] col);
        item_draws.delete();
        case (op)
            OP_START: begin
                pen_x     = ox;
                pen_y     = oy;
                margin_x  = ox;
                colors    = col;
                esc_state = ESC_IDLE;
                held      = 8'd0;
            end
            OP_CHAR:   feed_char(cp);
            OP_FINISH: flush_escape();
            default: ;
        endcase
        if (item_draws.size() > 0)
            item_draws[item_draws.size()-1].last_result = 1'b1;
        foreach (item_draws[i])
            expected_draws.push_back(item_draws[i]);
    endfunction

    // ---------------- script building ----------------

    function automatic void add_item(input logic [1:0] op, input logic [CP_W-1:0] cp,
                                     input logic [COORD_W-1:0] ox,
                                     input logic [COORD_W-1:0] oy,
                                     input logic [COLOR_W-1:0] col);
        stim_row_t r;
        r.kind  = ROW_ITEM;
        r.op    = op;
        r.cp    = cp;
        r.ox    = ox;
        r.oy    = oy;
        r.col   = col;
        r.typed = 1'b0;
        r.want  = '0;
        script.push_back(r);
    endfunction

    function automatic void add_char(input logic [CP_W-1:0] cp);
        add_item(OP_CHAR, cp, 16'($urandom), 16'($urandom), 8'($urandom));
    endfunction

    function automatic void add_typed(input logic [CP_W-1:0] cp, input draw_t want);
        add_char(cp);
        script[script.size()-1].typed = 1'b1;
        script[script.size()-1].want  = want;
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        stim_row_t r;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        r.typed   = 1'b0;
        r.want    = '0;
        script.push_back(r);
    endfunction

    // ---------------- drivers ----------------

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input logic [1:0] op, input logic [CP_W-1:0] cp,
                             input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                             input logic [COLOR_W-1:0] col,
                             input bit typed = 1'b0, input draw_t want = '0);
        if (burst_left == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        opcode       = op;
        codepoint    = cp;
        origin_x     = ox;
        origin_y     = oy;
        start_colors = col;
        in_valid     = 1'b1;
        forever begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        predict_draws(op, cp, ox, oy, col);
        // typed rows carry one draw, written out by hand
        if (typed)
            expected_draws[expected_draws.size()-1] = want;
        if (op != OP_UNUSED)
            items_sent++;
        burst_left--;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_char(input logic [CP_W-1:0] cp);
        send_item(OP_CHAR, cp, 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // Register writes only once all draws are out and the back end has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        in_valid = 1'b0;
        while (expected_draws.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we   = 1'b1;
        cfg_addr = idx;
        cfg_data = val;
        case (idx)
            CFG_LINE_HEIGHT:   line_h = val[GH_W-1:0];
            CFG_ESCAPE_CODE:   esc_cp = val[ESC_W-1:0];
            CFG_ESCAPE_ENABLE: esc_on = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [CP_W-1:0] rand_hex();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return CP_W'(digits[$urandom_range(0, 21)]);
    endfunction

    // Codepoint that breaks a pending escape (or restarts it)
    function automatic logic [CP_W-1:0] rand_breaker();
        case ($urandom_range(0, 5))
            0:       return CP_W'($urandom_range(8'h67, 8'h7e));
            1:       return INVALID_CP;
            2:       return NEWLINE_CP;
            3:       return CP_W'(esc_cp);
            4:       return rand_hex() + CP_W'($urandom_range(1, 4351) << 8);
            default: return CP_W'($urandom_range(0, 1114111));
        endcase
    endfunction

    // One random fragment of a text stream
    task automatic send_chunk();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            send_char(CP_W'($urandom_range(32, 126)));
        else if (pick < 40)
            send_char(CP_W'($urandom_range(0, 1114111)));
        else if (pick < 46)
            send_char(NEWLINE_CP);
        else if (pick < 50)
            send_char(INVALID_CP);
        else if (pick < 70) begin
            send_char(CP_W'(esc_cp));
            send_char(rand_hex());
            send_char(rand_hex());
        end
        else if (pick < 84) begin
            send_char(CP_W'(esc_cp));
            if ($urandom_range(0, 1))
                send_char(rand_hex());
            send_char(rand_breaker());
        end
        else if (pick < 90) begin
            if ($urandom_range(0, 1))
                send_char(CP_W'(esc_cp));
            if ($urandom_range(0, 2) == 0)
                send_char(rand_hex());
            send_item(OP_FINISH, CP_W'($urandom_range(0, 1114111)), 16'($urandom),
                      16'($urandom), 8'($urandom));
        end
        else if (pick < 97) begin
            if ($urandom_range(0, 2) == 0)
                send_char(CP_W'(esc_cp));
            send_item(OP_START, CP_W'($urandom_range(0, 1114111)), 16'($urandom),
                      16'($urandom), 8'($urandom));
        end
        else
            send_item(OP_UNUSED, CP_W'($urandom_range(0, 1114111)), 16'($urandom),
                      16'($urandom), 8'($urandom));
    endtask

    task automatic random_phase(input logic [CFG_W-1:0] gh, input logic [CFG_W-1:0] esc,
                                input logic [CFG_W-1:0] en);
        int goal;
        write_reg(CFG_LINE_HEIGHT, gh);
        write_reg(CFG_ESCAPE_CODE, esc);
        write_reg(CFG_ESCAPE_ENABLE, en);
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal)
            send_chunk();
    endtask

    // ---------------- receiver stall pattern ----------------

    initial begin
        int mode;
        int left;
        out_stall = 1'b0;
        mode      = 0;
        left      = 0;
        forever begin
            @(negedge clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 80);
            end
            left--;
            case (mode)
                0:       out_stall = 1'b0;
                1:       out_stall = ($urandom_range(0, 3) == 0);
                2:       out_stall = ($urandom_range(0, 3) != 0);
                default: out_stall = ~out_stall;
            endcase
        end
    end

    // ---------------- checker ----------------

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        draw_t want;
        if (rst_n && out_xfer) begin
            if (expected_draws.size() == 0) begin
                $error("draw command with none expected: dest_x %0d dest_y %0d", dest_x, dest_y);
                mismatches++;
            end
            else begin
                want = expected_draws.pop_front();
                check_field("dest_x", want.dest_x, dest_x);
                check_field("dest_y", want.dest_y, dest_y);
                check_field("src_x", want.src_x, src_x);
                check_field("src_y", want.src_y, src_y);
                check_field("bg_draw", want.bg_draw, bg_draw);
                check_field("bg_rgb", want.bg_rgb, bg_rgb);
                check_field("fg_rgb", want.fg_rgb, fg_rgb);
                check_field("last_result", want.last_result, last_result);
            end
        end
    end

    // Watchdog: too long without any transfer on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (in_xfer || out_xfer)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // ---------------- main sequence ----------------

    initial begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        opcode       = OP_START;
        codepoint    = '0;
        origin_x     = '0;
        origin_y     = '0;
        start_colors = '0;
        mismatches   = 0;
        burst_left   = 0;
        items_sent   = 0;
        pen_x        = '0;
        pen_y        = '0;
        margin_x     = '0;
        colors       = '0;
        esc_state    = ESC_IDLE;
        held         = '0;
        line_h       = 6'd8;
        esc_cp       = 8'd27;
        esc_on       = 1'b1;

        // Out of reset: black on black at the origin, then the codepoint extremes
        add_typed("A", '{16'sd0, 16'sd0, 8'd8, 21'd16, 1'b0, 24'h0, 24'h0, 1'b1});
        add_typed(21'd0, '{16'sd8, 16'sd0, 8'd0, 21'd0, 1'b0, 24'h0, 24'h0, 1'b1});
        add_typed(21'h10FFFF, '{16'sd16, 16'sd0, 8'd248, 21'd278520, 1'b0, 24'h0, 24'h0, 1'b1});
        add_char(INVALID_CP);
        // Start at the coordinate extremes, white background
        add_item(OP_START, 21'h1FFFFF, 16'h8000, 16'h7FFF, 8'hF0);
        add_typed("B", '{16'h8000, 16'h7FFF, 8'd16, 21'd16, 1'b1, 24'hffffff, 24'h0, 1'b1});
        add_char(NEWLINE_CP);
        // Good escape, then a char in the new colors
        add_char(21'd27);
        add_char("4");
        add_char("e");
        add_char("x");
        // Broken after the escape alone
        add_char(21'd27);
        add_char("g");
        // Broken after a digit by a codepoint whose low byte is a hex digit
        add_char(21'd27);
        add_char("1");
        add_char(21'h10041);
        // Broken by the invalid codepoint
        add_char(21'd27);
        add_char(INVALID_CP);
        // Finish flushes escape and digit
        add_char(21'd27);
        add_char("F");
        add_item(OP_FINISH, '0, '0, '0, '0);
        add_item(OP_FINISH, '0, '0, '0, '0);
        // Start discards a pending escape; the unused opcode does nothing
        add_char(21'd27);
        add_item(OP_START, 21'd27, 16'h7FFF, 16'h8000, 8'h0F);
        add_item(OP_UNUSED, 21'h1FFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        // Turning escapes off while one is pending still completes it
        add_char(21'd27);
        add_reg(CFG_ESCAPE_ENABLE, 8'd0);
        add_char("3");
        add_char("4");
        add_char(21'd27);
        // Escape code equal to newline: a broken sequence replays the newline
        add_reg(CFG_ESCAPE_CODE, 8'h0A);
        add_reg(CFG_ESCAPE_ENABLE, 8'd1);
        add_reg(CFG_LINE_HEIGHT, 8'd63);
        add_char(NEWLINE_CP);
        add_char("q");
        // Escape code is itself a hex digit: a broken sequence draws the held digit as text
        add_reg(CFG_ESCAPE_CODE, "a");
        add_char("a");
        add_char("a");
        add_char("!");

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG)
                write_reg(script[i].reg_idx, script[i].reg_val);
            else
                send_item(script[i].op, script[i].cp, script[i].ox, script[i].oy,
                          script[i].col, script[i].typed, script[i].want);
        end

        // Random streams under several register settings
        random_phase(8'd1, 8'd0, 8'd1);
        random_phase(8'd32, 8'd255, 8'd1);
        random_phase(8'd0, "a", 8'd1);
        random_phase(8'd63, 8'h0A, 8'd1);
        random_phase(8'($urandom_range(1, 32)), 8'($urandom), 8'd0);
        random_phase(8'($urandom_range(1, 32)), 8'd27, 8'd1);

        in_valid = 1'b0;
        while (expected_draws.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* color_escape_text_layout_top.f */
design/cetl_pkg.sv
design/cetl_front.sv
design/cetl_queue.sv
design/cetl_back.sv
design/color_escape_text_layout_top.sv
test/color_escape_text_layout_top_tb.sv
